// ===== hdl/npc_pkg.sv =====
// Shared types for the nearest palette color search block.
`default_nettype none
package npc_pkg;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_HOLD
    } npc_state_t;

    // Input transaction kinds carried on s_tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_MATCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;       // write one palette entry
        logic scan_start;  // latch query color and clear the scan address
        logic issue;       // read the next palette entry into the pipeline
        logic load_out;    // copy the best index into the output register
    } npc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_last;  // the address being issued is the last entry
        logic done;        // the last compare has finished
    } npc_stat_t;

    // Weights of the brightness term and scale of the squared distance.
    localparam logic signed [15:0] WEIGHT_R  = 16'sd30;
    localparam logic signed [15:0] WEIGHT_G  = 16'sd59;
    localparam logic signed [15:0] WEIGHT_B  = 16'sd11;
    localparam logic [13:0]        SQ_SCALE  = 14'd10000;

endpackage
`default_nettype wire

// ===== hdl/nearest_palette_color.sv =====
// A load is taken while the controller is idle. For a match, the scan reads one palette
// entry from the memory port each cycle, then the distance pipeline drains into m_tvalid.
// One load per cycle while idle; no input is taken during a match. A result left
// waiting in the output register stalls the input once the next match has finished.
// Reset: synchronous active-low aresetn clears the controller, pipeline flags and
// per-entry written flags, so every palette entry reads as black at once.
`default_nettype none
module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // entry_index, red, green, blue
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // best_index
);

    npc_pkg::npc_cmd_t  cmd;
    npc_pkg::npc_stat_t stat;

    // Sequencing of loads and scans.
    npc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Palette and distance datapath.
    npc_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .entry_index (s_tdata[7:0]),
        .red         (s_tdata[15:8]),
        .green       (s_tdata[23:16]),
        .blue        (s_tdata[31:24]),
        .best_index  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/npc_ctrl.sv =====
// Controller state machine for the nearest palette color search.
`default_nettype none
module npc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_op,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output npc_pkg::npc_cmd_t       cmd,
    input  wire npc_pkg::npc_stat_t stat
);

    npc_pkg::npc_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic in_xfer;
    logic out_free;

    assign in_xfer  = s_tvalid && (state_reg == npc_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            npc_pkg::ST_IDLE: begin
                if (in_xfer && (s_op == npc_pkg::OP_MATCH)) begin
                    state_next = npc_pkg::ST_SCAN;
                end
            end
            npc_pkg::ST_SCAN: begin
                if (stat.issue_last) begin
                    state_next = npc_pkg::ST_DRAIN;
                end
            end
            npc_pkg::ST_DRAIN: begin
                if (stat.done) begin
                    state_next = out_free ? npc_pkg::ST_IDLE : npc_pkg::ST_HOLD;
                end
            end
            npc_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = npc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = npc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            npc_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.wr_en      = in_xfer && (s_op == npc_pkg::OP_LOAD);
                cmd.scan_start = in_xfer && (s_op == npc_pkg::OP_MATCH);
            end
            npc_pkg::ST_SCAN: begin
                cmd.issue = 1'b1;
            end
            npc_pkg::ST_DRAIN: begin
                cmd.load_out = stat.done && out_free;
            end
            npc_pkg::ST_HOLD: begin
                cmd.load_out = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // The output register is full from a load until its transaction completes.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= npc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/npc_datapath.sv =====
// Palette memory, distance pipeline and best-match tracker.
`default_nettype none
module npc_datapath #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire npc_pkg::npc_cmd_t  cmd,
    output npc_pkg::npc_stat_t      stat,
    input  wire logic [7:0]         entry_index,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    output logic [7:0]              best_index
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int NSTG   = 6;

    // Palette storage; entries never written read as black.
    logic [23:0]                mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] ent_valid_reg;
    logic                       wr_ok;
    logic [ADDR_W-1:0]          wr_addr;

    // Scan state.
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        q_red_reg, q_green_reg, q_blue_reg;

    // Pipeline control, one slot per stage.
    logic [NSTG:1]     vld_reg;
    logic [NSTG:1]     last_reg;
    logic [ADDR_W-1:0] idx_reg [NSTG:1];

    // Pipeline data.
    logic [23:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic signed [8:0]  dr_reg, dg_reg, db_reg;
    logic [15:0]        sq_r_reg, sq_g_reg, sq_b_reg;
    logic signed [15:0] dv_reg;
    logic [17:0]        sq_sum_reg;
    logic [29:0]        dv2_reg, dv2_d_reg;
    logic [30:0]        wsq_reg;
    logic [31:0]        dist_reg;

    // Best match and result.
    logic [31:0]       best_dist_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic              done_reg;
    logic [7:0]        out_data_reg;

    // Combinational helpers.
    logic [23:0]        ent_color;
    logic signed [31:0] dv_prod;
    logic signed [17:0] sq_r_full, sq_g_full, sq_b_full;

    assign wr_ok   = cmd.wr_en && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign wr_addr = entry_index[ADDR_W-1:0];

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= {red, green, blue};
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Per-entry written flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= '0;
        end else if (wr_ok) begin
            ent_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Query latch and scan address.
    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            q_red_reg   <= red;
            q_green_reg <= green;
            q_blue_reg  <= blue;
        end
        if (!aresetn) begin
            addr_reg <= '0;
        end else if (cmd.scan_start) begin
            addr_reg <= '0;
        end else if (cmd.issue) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    assign stat.issue_last = (addr_reg == ADDR_W'(PALETTE_ENTRIES - 1));
    assign stat.done       = done_reg;

    // Pipeline control shift.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            last_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            vld_reg  <= {vld_reg[NSTG-1:1], cmd.issue};
            last_reg <= {last_reg[NSTG-1:1], cmd.issue && stat.issue_last};
            done_reg <= vld_reg[NSTG] && last_reg[NSTG];
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg[1] <= addr_reg;
        for (int s = 2; s <= NSTG; s++) begin
            idx_reg[s] <= idx_reg[s-1];
        end
        rd_valid_reg <= ent_valid_reg[addr_reg];
    end

    // Component differences.
    assign ent_color = rd_valid_reg ? rd_data_reg : 24'd0;

    always_ff @(posedge aclk) begin
        dr_reg <= $signed({1'b0, ent_color[23:16]}) - $signed({1'b0, q_red_reg});
        dg_reg <= $signed({1'b0, ent_color[15:8]})  - $signed({1'b0, q_green_reg});
        db_reg <= $signed({1'b0, ent_color[7:0]})   - $signed({1'b0, q_blue_reg});
    end

    // Squares of the differences and the brightness difference.
    assign sq_r_full = 18'(dr_reg) * 18'(dr_reg);
    assign sq_g_full = 18'(dg_reg) * 18'(dg_reg);
    assign sq_b_full = 18'(db_reg) * 18'(db_reg);

    always_ff @(posedge aclk) begin
        sq_r_reg <= sq_r_full[15:0];
        sq_g_reg <= sq_g_full[15:0];
        sq_b_reg <= sq_b_full[15:0];
        dv_reg   <= 16'(dr_reg) * npc_pkg::WEIGHT_R
                  + 16'(dg_reg) * npc_pkg::WEIGHT_G
                  + 16'(db_reg) * npc_pkg::WEIGHT_B;
    end

    // Sum of squares and squared brightness difference.
    assign dv_prod = 32'(dv_reg) * 32'(dv_reg);

    always_ff @(posedge aclk) begin
        sq_sum_reg <= 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);
        dv2_reg    <= dv_prod[29:0];
    end

    // Scale the squared color distance.
    always_ff @(posedge aclk) begin
        wsq_reg   <= 31'(sq_sum_reg) * 31'(npc_pkg::SQ_SCALE);
        dv2_d_reg <= dv2_reg;
    end

    // Full distance.
    always_ff @(posedge aclk) begin
        dist_reg <= 32'(wsq_reg) + 32'(dv2_d_reg);
    end

    // Keep the first entry, then only a strictly smaller distance.
    always_ff @(posedge aclk) begin
        if (vld_reg[NSTG]) begin
            if ((idx_reg[NSTG] == '0) || (dist_reg < best_dist_reg)) begin
                best_dist_reg <= dist_reg;
                best_idx_reg  <= idx_reg[NSTG];
            end
        end
    end

    // Output data register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= 8'(best_idx_reg);
        end
    end

    assign best_index = out_data_reg;

endmodule
`default_nettype wire
